// ===== rtl/core/rotary_move_supervisor_top_defines.svh =====
// assertion macros for the rotary move supervisor
// used by rotary_move_supervisor_top; needs clk_i and rst_ni in scope
`ifndef ROTARY_MOVE_SUPERVISOR_TOP_DEFINES_SVH
`define ROTARY_MOVE_SUPERVISOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define RMS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rotary move supervisor check failed");

// next-cycle implication, sampled on clk_i, off while in reset
`define RMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rotary move supervisor check failed");

`endif

// ===== rtl/core/rms_pkg.sv =====
// shared types and constants for the rotary move supervisor
// no dependencies
package rms_pkg;

  localparam int unsigned STEPS_PER_CIRCLE = 4096;
  localparam int unsigned HALF_CIRCLE      = STEPS_PER_CIRCLE / 2;

  localparam logic [7:0] STALL_THRESHOLD_RESET = 8'd10;
  localparam logic [7:0] UNCHANGED_MAX         = 8'hFF;

  // register map: one bit of word index
  localparam int unsigned PADDR_W = 3;
  localparam logic        REG_STALL_THRESHOLD = 1'b0;

  typedef enum logic [1:0] {
    OP_ZERO = 2'd0,
    OP_MOVE = 2'd1,
    OP_POLL = 2'd2,
    OP_STOP = 2'd3
  } rms_op_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_MOVE    = 3'd1,
    EV_UPDATE  = 3'd2,
    EV_ARRIVED = 3'd3,
    EV_STALLED = 3'd4
  } rms_event_e;

  typedef struct packed {
    rms_event_e        event_res;
    logic signed [15:0] drive_target;
    logic signed [15:0] relative_position;
    logic              keep_polling;
  } rms_result_t;

endpackage

// ===== rtl/core/rotary_move_supervisor_top.sv =====
// top level of the rotary move supervisor
// depends on rms_pkg, rms_core, rms_skid and rotary_move_supervisor_top_defines.svh
//
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------------
//  input   | in_valid_i/in_stall_o | operation_i, position_i, target_steps_i
//  result  | out_valid_o/out_stall_i | event_res_o, drive_target_o,
//          |                       | relative_position_o, keep_polling_o
//  config  | psel/penable/pwrite   | paddr, pwdata, prdata (pready tied high)
//
// one transaction per cycle while in_stall_o is low: each accepted item's result
// is registered, set by a single pass of compare/add logic in rms_core
// a skid register lets one more transaction in while the output is stalled;
// in_stall_o rises only when both output and skid entries are held
// reset is asynchronous, active low; it clears the core state and the valid flags
// of the result buffer and sets the stall threshold to ten
`include "rotary_move_supervisor_top_defines.svh"

module rotary_move_supervisor_top import rms_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic signed [15:0] position_i,
  input  logic signed [15:0] target_steps_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         event_res_o,
  output logic signed [15:0] drive_target_o,
  output logic signed [15:0] relative_position_o,
  output logic               keep_polling_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic        accept;
  logic        buf_full;
  rms_result_t result;
  rms_result_t out_data;
  logic [7:0]  thr_q;
  logic        cfg_wr;
  logic        reg_idx;

  // ---- configuration register ----
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= STALL_THRESHOLD_RESET;
    end else if (cfg_wr && (reg_idx == REG_STALL_THRESHOLD)) begin
      thr_q <= pwdata[7:0];
    end
  end

  // reads return the threshold, anything else reads as zero
  assign prdata = (reg_idx == REG_STALL_THRESHOLD) ? {24'd0, thr_q} : 32'd0;

  // ---- transaction acceptance ----
  // buffer full is the only reason to hold off the source
  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  // state and result logic; state updates at the accepting edge
  rms_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .operation_i       (operation_i),
    .position_i        (position_i),
    .target_steps_i    (target_steps_i),
    .stall_threshold_i (thr_q),
    .result_o          (result)
  );

  // output register with skid entry
  rms_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign event_res_o         = out_data.event_res;
  assign drive_target_o      = out_data.drive_target;
  assign relative_position_o = out_data.relative_position;
  assign keep_polling_o      = out_data.keep_polling;

  // ---- checks ----
  // the skid entry is only ever occupied behind a held output
  `RMS_ASSERT_IMPL(a_skid_behind_out, in_stall_o, out_valid_o)
  // a drive target appears only with a move result
  `RMS_ASSERT_IMPL(a_drive_only_on_move,
      out_valid_o && (event_res_o != EV_MOVE), drive_target_o == 16'sd0)
  // a move result always leaves the move running
  `RMS_ASSERT_IMPL(a_move_keeps_polling,
      out_valid_o && (event_res_o == EV_MOVE), keep_polling_o)
  // arrival or stall always ends the move
  `RMS_ASSERT_IMPL(a_end_stops_polling,
      out_valid_o && ((event_res_o == EV_ARRIVED) || (event_res_o == EV_STALLED)),
      !keep_polling_o)

endmodule

// ===== rtl/core/rms_core.sv =====
// move supervision state and per-transaction result logic
// depends on rms_pkg
module rms_core import rms_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [1:0]         operation_i,
  input  logic signed [15:0] position_i,
  input  logic signed [15:0] target_steps_i,
  input  logic [7:0]         stall_threshold_i,
  output rms_result_t        result_o
);

  localparam logic signed [17:0] CIRCLE = 18'(STEPS_PER_CIRCLE);
  localparam logic signed [17:0] HALF   = 18'(HALF_CIRCLE);

  logic [15:0] ref_q, ref_d;
  logic [15:0] origin_q, origin_d;
  logic [15:0] dist_q, dist_d;
  logic [15:0] last_q, last_d;
  logic [7:0]  cnt_q, cnt_d;
  logic        active_q, active_d;

  rms_op_e            op;
  logic signed [15:0] dest0;
  logic signed [17:0] mv_diff;
  logic signed [17:0] mv_dest;
  logic signed [15:0] poll_dest;
  logic signed [17:0] poll_diff;
  logic               forward;
  logic               arrived;
  logic [7:0]         cnt_upd;

  assign op = rms_op_e'(operation_i);

  // move target, shorter way round
  assign dest0   = target_steps_i + $signed(ref_q);
  assign mv_diff = 18'(dest0) - 18'(position_i);

  always_comb begin
    if (mv_diff < -HALF) begin
      mv_dest = 18'(dest0) + CIRCLE;
    end else if (mv_diff > HALF) begin
      mv_dest = 18'(dest0) - CIRCLE;
    end else begin
      mv_dest = 18'(dest0);
    end
  end

  // poll arrival test
  assign poll_dest = $signed(origin_q + dist_q);
  assign forward   = $signed(dist_q) > 16'sd0;
  assign poll_diff = 18'(position_i) - 18'(poll_dest);
  assign arrived   = forward ? (poll_diff >= 18'sd0) : (poll_diff <= 18'sd0);

  always_comb begin
    if (last_q != position_i) begin
      cnt_upd = '0;
    end else if (cnt_q < UNCHANGED_MAX) begin
      cnt_upd = cnt_q + 8'd1;
    end else begin
      cnt_upd = cnt_q;
    end
  end

  always_comb begin
    ref_d    = ref_q;
    origin_d = origin_q;
    dist_d   = dist_q;
    last_d   = last_q;
    cnt_d    = cnt_q;
    active_d = active_q;
    result_o.event_res         = EV_NONE;
    result_o.drive_target      = '0;
    result_o.relative_position = '0;
    case (op)
      OP_ZERO: begin
        ref_d    = position_i;
        origin_d = position_i;
        dist_d   = '0;
      end
      OP_MOVE: begin
        origin_d = position_i;
        dist_d   = 16'(mv_dest - 18'(position_i));
        active_d = 1'b1;
        result_o.event_res    = EV_MOVE;
        result_o.drive_target = 16'(mv_dest);
      end
      OP_POLL: begin
        if (active_q) begin
          if (arrived) begin
            active_d = 1'b0;
            result_o.event_res = EV_ARRIVED;
          end else begin
            last_d = position_i;
            if (cnt_upd < stall_threshold_i) begin
              cnt_d = cnt_upd;
              result_o.event_res         = EV_UPDATE;
              result_o.relative_position = position_i - $signed(ref_q);
            end else begin
              cnt_d    = '0;
              active_d = 1'b0;
              result_o.event_res = EV_STALLED;
            end
          end
        end
      end
      OP_STOP: begin
        active_d = 1'b0;
      end
      default: begin
        active_d = active_q;
      end
    endcase
    result_o.keep_polling = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q    <= '0;
      origin_q <= '0;
      dist_q   <= '0;
      last_q   <= '0;
      cnt_q    <= '0;
      active_q <= 1'b0;
    end else if (accept_i) begin
      ref_q    <= ref_d;
      origin_q <= origin_d;
      dist_q   <= dist_d;
      last_q   <= last_d;
      cnt_q    <= cnt_d;
      active_q <= active_d;
    end
  end

endmodule

// ===== rtl/core/rms_skid.sv =====
// two-entry result buffer: output register plus skid register
// depends on rms_pkg
module rms_skid import rms_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  rms_result_t push_data_i,
  output logic        full_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rms_result_t out_data_o
);

  logic        out_valid_q, out_valid_d;
  logic        skid_valid_q, skid_valid_d;
  rms_result_t out_q, out_d;
  rms_result_t skid_q, skid_d;
  logic        pop;

  assign pop = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_d       = push_data_i;
        skid_valid_d = push_i;
      end else begin
        out_d       = push_data_i;
        out_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = push_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
